### design/ramq_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ramq_pkg: shared constants, types and modular helpers
// Holds the sizes, operation codes, queue entry type and the modulus helpers
// used by the front end, the back end and the top level.
// ---------------------------------------------------------------------------
package ramq_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int BLK_LEN      = 32;
    localparam int MODULUS      = 10007;
    localparam int NUM_BLOCKS   = (MAX_ELEMENTS + BLK_LEN - 1) / BLK_LEN;
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);
    localparam int OFS_W        = $clog2(BLK_LEN);
    localparam int BLK_W        = IDX_W - OFS_W;
    localparam int VAL_W        = 14;
    localparam int CNT_W        = 11;
    localparam int PROD_W       = 2 * VAL_W;

    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_ADD   = 2'd1;
    localparam logic [1:0] FUNC_MUL   = 2'd2;
    localparam logic [1:0] FUNC_QUERY = 2'd3;

    localparam logic [VAL_W-1:0]  MOD_V  = VAL_W'(MODULUS);
    localparam logic [CNT_W-1:0]  MAX_C  = CNT_W'(MAX_ELEMENTS);

    // classified item handed from the front end to the back end
    typedef struct packed {
        logic [1:0]       func;
        logic             valid_op;   // in range; otherwise drop (query -> 0)
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] hi;
        logic [VAL_W-1:0] c;
    } cmd_t;

    // single conditional subtract: x < 2*MODULUS
    function automatic logic [VAL_W-1:0] mod_fix(input logic [VAL_W:0] x);
        logic [VAL_W:0] d;
        d = x - {1'b0, MOD_V};
        mod_fix = (x >= {1'b0, MOD_V}) ? d[VAL_W-1:0] : x[VAL_W-1:0];
    endfunction

endpackage

### design/ramq_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ramq_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module ramq_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### design/ramq_modmul.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ramq_modmul: pipelined modular multiply
// Multiplies two residues, then reduces the product by reciprocal
// multiplication and one conditional subtract; done pulses through v1_reg,
// v2_reg and done_reg after go, with the result on y for that cycle.
// ---------------------------------------------------------------------------
module ramq_modmul
    import ramq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  logic [VAL_W-1:0] a,
    input  logic [VAL_W-1:0] b,
    output logic             done,
    output logic [VAL_W-1:0] y
);
    // floor(2^PROD_W / MODULUS); the quotient estimate is short by at most one
    localparam logic [PROD_W-1:0] RECIP = PROD_W'((64'd1 << PROD_W) / MODULUS);

    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [PROD_W-1:0]   rem_reg;
    logic [VAL_W-1:0]    quo_reg, quo_next;
    logic [VAL_W-1:0]    y_reg, y_next;
    logic                v1_reg, v2_reg, done_reg;
    logic [2*PROD_W-1:0] scaled;
    logic [PROD_W-1:0]   back;
    logic [PROD_W-1:0]   diff;

    assign prod_next = PROD_W'(a) * PROD_W'(b);
    assign scaled    = (2*PROD_W)'(prod_reg) * (2*PROD_W)'(RECIP);
    assign quo_next  = scaled[PROD_W +: VAL_W];
    assign back      = PROD_W'(quo_reg) * PROD_W'(MOD_V);
    assign diff      = rem_reg - back;   // below 2*MODULUS
    assign y_next    = mod_fix(diff[VAL_W:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= go;
            v2_reg   <= v1_reg;
            done_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        rem_reg  <= prod_reg;
        quo_reg  <= quo_next;
        y_reg    <= y_next;
    end

    assign done = done_reg;
    assign y    = y_reg;
endmodule

### design/ramq_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ramq_front: command intake and classification
// Reduces the operand, checks the index range against the element count and
// pushes a classified item into a two-entry queue.
// ---------------------------------------------------------------------------
module ramq_front
    import ramq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       func,
    input  logic [IDX_W-1:0] lo_index,
    input  logic [IDX_W-1:0] hi_index,
    input  logic [VAL_W-1:0] operand,
    output logic             q_valid,
    output cmd_t             q_head,
    input  logic             q_pop
);
    logic [CNT_W-1:0] count_reg, count_next;
    cmd_t             ent_reg [2];
    logic [1:0]       fill_reg, fill_next;
    logic             rd_reg, rd_next;
    logic             wr_ptr;
    logic             push;
    cmd_t             cmd_in;
    logic             lo_ok, hi_ok;

    assign busy   = (fill_reg == 2'd2);
    assign push   = start && !busy;
    assign wr_ptr = rd_reg ^ fill_reg[0];

    assign lo_ok = {1'b0, lo_index} < count_reg;
    assign hi_ok = {1'b0, hi_index} < count_reg;

    always_comb
    begin
        cmd_in.func = func;
        cmd_in.lo   = lo_index;
        cmd_in.hi   = hi_index;
        cmd_in.c    = mod_fix({1'b0, operand});
        case (func)
            FUNC_WRITE, FUNC_QUERY: cmd_in.valid_op = lo_ok;
            default:                cmd_in.valid_op = (lo_index <= hi_index) && hi_ok;
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (cfg_we)
        begin
            count_next = (cfg_wdata > MAX_C) ? MAX_C : cfg_wdata;
        end
        fill_next = fill_reg + 2'(push) - 2'(q_pop);
        rd_next   = q_pop ? !rd_reg : rd_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= MAX_C;
            fill_reg  <= '0;
            rd_reg    <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            fill_reg  <= fill_next;
            rd_reg    <= rd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr] <= cmd_in;
        end
    end

    assign q_valid = (fill_reg != 2'd0);
    assign q_head  = ent_reg[rd_reg];
endmodule

### design/ramq_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ramq_back: command execution over the element RAM and block tags
// Sequences push-downs, element updates, tag updates and queries.
// ---------------------------------------------------------------------------
module ramq_back
    import ramq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  cmd_t             q_head,
    output logic             q_pop,
    output logic             query_valid,
    output logic [VAL_W-1:0] query_value
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SRD   = 4'd1;  // settle: read element
    localparam logic [3:0] S_SMUL  = 4'd2;  // settle: multiply by tag
    localparam logic [3:0] S_SWR   = 4'd3;  // settle: add tag, write
    localparam logic [3:0] S_TRD   = 4'd4;  // touch: read element
    localparam logic [3:0] S_TMUL  = 4'd5;  // touch: multiply or add
    localparam logic [3:0] S_TWR   = 4'd6;
    localparam logic [3:0] S_BTAG  = 4'd7;  // interior tags: multiply mul tag, or add to add tag
    localparam logic [3:0] S_BTAG2 = 4'd8;  // interior tags: multiply add tag
    localparam logic [3:0] S_QRD   = 4'd9;
    localparam logic [3:0] S_QMUL  = 4'd10;
    localparam logic [3:0] S_QOUT  = 4'd11;
    localparam logic [3:0] S_WWR   = 4'd12; // plain element write

    logic [3:0]       st_reg, st_next;
    cmd_t             cmd_reg, cmd_next;
    logic [1:0]       phase_reg, phase_next; // 0 left block, 1 interior, 2 right
    logic [BLK_W-1:0] blk_reg, blk_next;
    logic [OFS_W-1:0] ofs_reg, ofs_next;
    logic [VAL_W-1:0] tmp_reg, tmp_next;
    logic [VAL_W-1:0] mul_tag [NUM_BLOCKS];
    logic [VAL_W-1:0] add_tag [NUM_BLOCKS];
    logic             tag_we_m, tag_we_a;
    logic [VAL_W-1:0] tag_wm, tag_wa;
    logic             out_v_reg, out_v_next;
    logic [VAL_W-1:0] out_reg, out_next;

    logic             ram_we;
    logic [IDX_W-1:0] ram_addr;
    logic [VAL_W-1:0] ram_wdata, ram_rdata;

    logic             mm_go, mm_done;
    logic [VAL_W-1:0] mm_a, mm_b, mm_y;

    logic [BLK_W-1:0] br;
    logic [IDX_W-1:0] cur_idx;
    logic             is_mul;
    logic [VAL_W-1:0] tm, ta;
    logic [VAL_W-1:0] sum_tag;
    logic [VAL_W-1:0] sum_c;

    assign br      = cmd_reg.hi[IDX_W-1:OFS_W];
    assign cur_idx = {blk_reg, ofs_reg};
    assign is_mul  = (cmd_reg.func == FUNC_MUL);
    assign tm      = mul_tag[blk_reg];
    assign ta      = add_tag[blk_reg];
    assign sum_tag = mod_fix({1'b0, mm_y} + {1'b0, ta});
    assign sum_c   = mod_fix({1'b0, ram_rdata} + {1'b0, cmd_reg.c});

    ramq_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ELEMENTS)) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (ram_wdata),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    ramq_modmul u_mul (
        .clk  (clk),
        .rst_n(rst_n),
        .go   (mm_go),
        .a    (mm_a),
        .b    (mm_b),
        .done (mm_done),
        .y    (mm_y)
    );

    always_comb
    begin
        st_next    = st_reg;
        cmd_next   = cmd_reg;
        phase_next = phase_reg;
        blk_next   = blk_reg;
        ofs_next   = ofs_reg;
        tmp_next   = tmp_reg;
        out_v_next = 1'b0;
        out_next   = out_reg;
        q_pop      = 1'b0;
        ram_we     = 1'b0;
        ram_addr   = cur_idx;
        ram_wdata  = tmp_reg;
        mm_go      = 1'b0;
        mm_a       = ram_rdata;
        mm_b       = tm;
        tag_we_m   = 1'b0;
        tag_we_a   = 1'b0;
        tag_wm     = tm;
        tag_wa     = ta;
        case (st_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_head;
                    blk_next = q_head.lo[IDX_W-1:OFS_W];
                    ofs_next = '0;
                    phase_next = 2'd0;
                    if (q_head.func == FUNC_QUERY)
                    begin
                        if (q_head.valid_op)
                        begin
                            ofs_next = q_head.lo[OFS_W-1:0];
                            st_next  = S_QRD;
                        end
                        else
                        begin
                            out_v_next = 1'b1;
                            out_next   = '0;
                        end
                    end
                    else if (q_head.valid_op)
                    begin
                        st_next = S_SRD;
                    end
                end
            end
            S_SRD:
            begin
                st_next = S_SMUL;
            end
            S_SMUL:
            begin
                mm_go   = 1'b1;
                st_next = S_SWR;
            end
            S_SWR:
            begin
                if (mm_done)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = sum_tag;
                    if (ofs_reg == OFS_W'(BLK_LEN - 1))
                    begin
                        tag_we_m = 1'b1;
                        tag_wm   = VAL_W'(1);
                        tag_we_a = 1'b1;
                        tag_wa   = '0;
                        if (cmd_reg.func == FUNC_WRITE)
                        begin
                            ofs_next = cmd_reg.lo[OFS_W-1:0];
                            st_next  = S_WWR;
                        end
                        else
                        begin
                            ofs_next = (phase_reg == 2'd0) ? cmd_reg.lo[OFS_W-1:0] : '0;
                            st_next  = S_TRD;
                        end
                    end
                    else
                    begin
                        ofs_next = ofs_reg + 1'b1;
                        st_next  = S_SRD;
                    end
                end
            end
            S_WWR:
            begin
                ram_we    = 1'b1;
                ram_wdata = cmd_reg.c;
                st_next   = S_IDLE;
            end
            S_TRD:
            begin
                st_next = S_TMUL;
            end
            S_TMUL:
            begin
                if (is_mul)
                begin
                    mm_go   = 1'b1;
                    mm_b    = cmd_reg.c;
                    st_next = S_TWR;
                end
                else
                begin
                    tmp_next = sum_c;
                    st_next  = S_TWR;
                end
            end
            S_TWR:
            begin
                if (!is_mul || mm_done)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = is_mul ? mm_y : tmp_reg;
                    if (cur_idx == cmd_reg.hi)
                    begin
                        st_next = S_IDLE;
                    end
                    else if (ofs_reg == OFS_W'(BLK_LEN - 1))
                    begin
                        // left block done, walk any interior tags then settle right
                        if (blk_reg + 1'b1 == br)
                        begin
                            blk_next   = br;
                            ofs_next   = '0;
                            phase_next = 2'd2;
                            st_next    = S_SRD;
                        end
                        else
                        begin
                            blk_next   = blk_reg + 1'b1;
                            phase_next = 2'd1;
                            st_next    = S_BTAG;
                        end
                    end
                    else
                    begin
                        ofs_next = ofs_reg + 1'b1;
                        st_next  = S_TRD;
                    end
                end
            end
            S_BTAG:
            begin
                if (is_mul)
                begin
                    mm_go    = 1'b1;
                    mm_a     = tm;
                    mm_b     = cmd_reg.c;
                    tmp_next = '0;
                    st_next  = S_BTAG2;
                end
                else
                begin
                    tag_we_a = 1'b1;
                    tag_wa   = mod_fix({1'b0, ta} + {1'b0, cmd_reg.c});
                    if (blk_reg + 1'b1 == br)
                    begin
                        blk_next   = br;
                        ofs_next   = '0;
                        phase_next = 2'd2;
                        st_next    = S_SRD;
                    end
                    else
                    begin
                        blk_next = blk_reg + 1'b1;
                    end
                end
            end
            S_BTAG2:
            begin
                // tmp_reg == 0: waiting for mul tag; 1: waiting for add tag
                if (mm_done)
                begin
                    if (tmp_reg == '0)
                    begin
                        tag_we_m = 1'b1;
                        tag_wm   = mm_y;
                        mm_go    = 1'b1;
                        mm_a     = ta;
                        mm_b     = cmd_reg.c;
                        tmp_next = VAL_W'(1);
                    end
                    else
                    begin
                        tag_we_a = 1'b1;
                        tag_wa   = mm_y;
                        tmp_next = '0;
                        if (blk_reg + 1'b1 == br)
                        begin
                            blk_next   = br;
                            ofs_next   = '0;
                            phase_next = 2'd2;
                            st_next    = S_SRD;
                        end
                        else
                        begin
                            blk_next = blk_reg + 1'b1;
                            st_next  = S_BTAG;
                        end
                    end
                end
            end
            S_QRD:
            begin
                st_next = S_QMUL;
            end
            S_QMUL:
            begin
                mm_go   = 1'b1;
                st_next = S_QOUT;
            end
            S_QOUT:
            begin
                if (mm_done)
                begin
                    out_v_next = 1'b1;
                    out_next   = sum_tag;
                    st_next    = S_IDLE;
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= S_IDLE;
            out_v_reg <= 1'b0;
            tmp_reg   <= '0;
            for (int i = 0; i < NUM_BLOCKS; i++)
            begin
                mul_tag[i] <= VAL_W'(1);
                add_tag[i] <= '0;
            end
        end
        else
        begin
            st_reg    <= st_next;
            out_v_reg <= out_v_next;
            tmp_reg   <= tmp_next;
            if (tag_we_m)
            begin
                mul_tag[blk_reg] <= tag_wm;
            end
            if (tag_we_a)
            begin
                add_tag[blk_reg] <= tag_wa;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        phase_reg <= phase_next;
        blk_reg   <= blk_next;
        ofs_reg   <= ofs_next;
        out_reg   <= out_next;
    end

    assign query_valid = out_v_reg;
    assign query_value = out_reg;
endmodule

### design/range_affine_mod_point_query.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// range_affine_mod_point_query: element write, range add/multiply, point query mod 10007
// Elements sit in a 1024-entry RAM in blocks of 32, each block with a lazy
// affine tag held in flip-flops.
// ---------------------------------------------------------------------------
// Work per item: a query reads, multiplies and strobes its result; a write pops,
// pushes down the 32-element block and writes the element; a range update does up
// to two push-downs, two partial walks and 30 interior tag updates.
// Execution takes one item at a time, which must finish before the next is popped;
// a two-entry queue holds items, busy is high when full; receiver cannot stall.
// Reset: tags to identity, count to 1024, queue empty; element RAM not cleared.
module range_affine_mod_point_query
    import ramq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       func,
    input  logic [IDX_W-1:0] lo_index,
    input  logic [IDX_W-1:0] hi_index,
    input  logic [VAL_W-1:0] operand,
    output logic             query_valid,
    output logic [VAL_W-1:0] query_value
);
    // queue between intake and execution
    logic q_valid;
    logic q_pop;
    cmd_t q_head;

    // front end: range check, operand reduction, queue
    ramq_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .start    (start),
        .busy     (busy),
        .func     (func),
        .lo_index (lo_index),
        .hi_index (hi_index),
        .operand  (operand),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_pop    (q_pop)
    );

    // back end: push-downs, element walks, tag updates, queries
    ramq_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .query_valid(query_valid),
        .query_value(query_value)
    );
endmodule

### tb/sv/range_affine_mod_point_query_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// range_affine_mod_point_query_tb: self-checking bench for the block
// Drives writes, range add/multiply and point queries through the
// start/busy port and mirrors the block's lazy-tag array in a local
// predictor. Each query strobe is compared with the oldest expected value.
// A directed table comes first, then randomized phases at several element
// counts. Each count change waits for the block to go idle.
// ---------------------------------------------------------------------------
module range_affine_mod_point_query_tb;
    import ramq_pkg::*;

    localparam int  DRAIN_CYCLES = 12000;  // well over three worst-case range updates
    localparam longint CYCLE_LIMIT = 20_000_000;

    typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;
    typedef struct {
        row_kind_t  kind;
        logic [1:0] f;
        int         lo;
        int         hi;
        int         op;
        bit         typed;   // expected value given in the row
        int         val;
    } stim_row_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CNT_W-1:0] cfg_wdata;
    logic             start;
    logic             busy;
    logic [1:0]       func;
    logic [IDX_W-1:0] lo_index;
    logic [IDX_W-1:0] hi_index;
    logic [VAL_W-1:0] operand;
    logic             query_valid;
    logic [VAL_W-1:0] query_value;

    range_affine_mod_point_query DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .start      (start),
        .busy       (busy),
        .func       (func),
        .lo_index   (lo_index),
        .hi_index   (hi_index),
        .operand    (operand),
        .query_valid(query_valid),
        .query_value(query_value)
    );

    // mirror of the block: elements, per-block affine tags, element count
    int  mirror_elem [MAX_ELEMENTS];
    int  mirror_mul  [NUM_BLOCKS];
    int  mirror_add  [NUM_BLOCKS];
    int  live_count;
    bit  ever_written [MAX_ELEMENTS];   // in-range queries only hit these

    int  pending_values [$];   // query values still to arrive
    int  fail_count;
    bit  quiet;                // no idle bursts
    longint cycle_count;

    stim_row_t seq_rows [26];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop on a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic int mmul(int x, int y);
        return (x * y) % MODULUS;
    endfunction

    function automatic int madd(int x, int y);
        return (x + y) % MODULUS;
    endfunction

    // fold a block's tag into all of its elements, then clear the tag
    function automatic void push_tag(int blk);
        for (int i = blk * BLK_LEN; i < (blk + 1) * BLK_LEN; i++)
            mirror_elem[i] = madd(mmul(mirror_elem[i], mirror_mul[blk]), mirror_add[blk]);
        mirror_mul[blk] = 1;
        mirror_add[blk] = 0;
    endfunction

    function automatic void apply_span(int from, int to, bit is_mul, int c);
        for (int i = from; i <= to; i++)
            mirror_elem[i] = is_mul ? mmul(mirror_elem[i], c) : madd(mirror_elem[i], c);
    endfunction

    function automatic void range_affine(int lo, int hi, bit is_mul, int c);
        int bl;
        int br;
        bl = lo / BLK_LEN;
        br = hi / BLK_LEN;
        push_tag(bl);
        if (bl == br)
        begin
            apply_span(lo, hi, is_mul, c);
            return;
        end
        apply_span(lo, (bl + 1) * BLK_LEN - 1, is_mul, c);
        for (int b = bl + 1; b < br; b++)
        begin
            if (is_mul)
            begin
                mirror_mul[b] = mmul(mirror_mul[b], c);
                mirror_add[b] = mmul(mirror_add[b], c);
            end
            else
                mirror_add[b] = madd(mirror_add[b], c);
        end
        push_tag(br);
        apply_span(br * BLK_LEN, hi, is_mul, c);
    endfunction

    // advance the mirror by one accepted item; returns 1 with a query value
    function automatic bit predict_item(logic [1:0] f, int lo, int hi, int op,
                                        output int qv);
        int c;
        c  = op % MODULUS;
        qv = 0;
        case (f)
            FUNC_QUERY:
            begin
                if (lo < live_count)
                    qv = madd(mmul(mirror_elem[lo], mirror_mul[lo / BLK_LEN]),
                              mirror_add[lo / BLK_LEN]);
                return 1'b1;
            end
            FUNC_WRITE:
            begin
                if (lo < live_count)
                begin
                    push_tag(lo / BLK_LEN);
                    mirror_elem[lo]  = c;
                    ever_written[lo] = 1'b1;
                end
            end
            default:
            begin
                if (lo <= hi && hi < live_count)
                    range_affine(lo, hi, f == FUNC_MUL, c);
            end
        endcase
        return 1'b0;
    endfunction

    // compare every strobe with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && query_valid)
        begin
            if (pending_values.size() == 0)
            begin
                $error("query_value: no result expected, got %0d", query_value);
                fail_count++;
            end
            else
            begin
                int want;
                want = pending_values.pop_front();
                if (query_value !== VAL_W'(want))
                begin
                    $error("query_value: expected %0d, actual %0d", want, query_value);
                    fail_count++;
                end
            end
        end
    end

    // drop start for a random burst, sometimes
    task automatic maybe_idle();
        int n;
        if (quiet || $urandom_range(0, 3) != 0)
            return;
        n = $urandom_range(1, 12);
        @(negedge clk);
        start <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // present one item, hold it until accepted, then book the expectation
    task automatic send_item(logic [1:0] f, int lo, int hi, int op, bit typed, int val);
        int qv;
        @(negedge clk);
        start    <= 1'b1;
        func     <= f;
        lo_index <= IDX_W'(lo);
        hi_index <= IDX_W'(hi);
        operand  <= VAL_W'(op);
        do
            @(posedge clk);
        while (busy);
        if (predict_item(f, lo, hi, op, qv))
            pending_values.push_back(typed ? val : qv);
        maybe_idle();
    endtask

    // wait out all expected results and the tail of any silent work
    task automatic wait_idle();
        @(negedge clk);
        start <= 1'b0;
        while (pending_values.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_count(int v);
        wait_idle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= CNT_W'(v);
        @(negedge clk);
        cfg_we    <= 1'b0;
        live_count = (v > MAX_ELEMENTS) ? MAX_ELEMENTS : v;
    endtask

    function automatic int pick_operand();
        int corner [5] = '{0, 1, 10006, 10007, 16383};
        if ($urandom_range(0, 9) == 0)
            return corner[$urandom_range(0, 4)];
        return $urandom_range(0, 16383);
    endfunction

    task automatic random_item();
        logic [1:0] f;
        int lo;
        int hi;
        int r;
        r  = $urandom_range(0, 99);
        f  = (r < 30) ? FUNC_WRITE : (r < 50) ? FUNC_ADD : (r < 70) ? FUNC_MUL : FUNC_QUERY;
        lo = (live_count > 0) ? $urandom_range(0, live_count - 1) : 0;
        // now and then aim past the live elements
        if (live_count < MAX_ELEMENTS && $urandom_range(0, 9) == 0)
            lo = $urandom_range(live_count, MAX_ELEMENTS - 1);
        hi = $urandom_range(0, 1023);
        if (f == FUNC_ADD || f == FUNC_MUL)
        begin
            r = $urandom_range(0, 99);
            if (r < 75)
                hi = lo + $urandom_range(0, 40);
            else if (r < 90)
                hi = $urandom_range(lo, MAX_ELEMENTS - 1);
            else if (lo > 0)
                hi = $urandom_range(0, lo - 1);   // empty range
            if (hi > MAX_ELEMENTS - 1)
                hi = MAX_ELEMENTS - 1;
        end
        // never read an in-range element that was not written; write it instead
        if (f == FUNC_QUERY && lo < live_count && !ever_written[lo])
            f = FUNC_WRITE;
        send_item(f, lo, hi, pick_operand(), 1'b0, 0);
    endtask

    initial
    begin
        int counts [7] = '{1024, 1, 0, 2047, 37, 1000, 0};
        int items  [7] = '{200, 80, 40, 200, 120, 180, 80};

        seq_rows = '{
            '{ROW_ITEM, FUNC_WRITE,    0,    0, 16383, 1'b0,     0},
            '{ROW_ITEM, FUNC_QUERY,    0, 1023,     0, 1'b1,  6376},
            '{ROW_ITEM, FUNC_WRITE, 1023,    0,     0, 1'b0,     0},
            '{ROW_ITEM, FUNC_QUERY, 1023,    0,     0, 1'b1,     0},
            '{ROW_ITEM, FUNC_WRITE,    5,    0, 10006, 1'b0,     0},
            '{ROW_ITEM, FUNC_QUERY,    5,    0,     0, 1'b1, 10006},
            '{ROW_ITEM, FUNC_WRITE,    5,    0, 10007, 1'b0,     0},
            '{ROW_ITEM, FUNC_QUERY,    5,    0,     0, 1'b1,     0},
            '{ROW_ITEM, FUNC_WRITE,   40,    0,   777, 1'b0,     0},
            '{ROW_ITEM, FUNC_ADD,      0, 1023, 16383, 1'b0,     0},
            '{ROW_ITEM, FUNC_QUERY,    0,    0,     0, 1'b0,     0},
            '{ROW_ITEM, FUNC_MUL,      3,   70, 10006, 1'b0,     0},
            '{ROW_ITEM, FUNC_QUERY,   40,    0,     0, 1'b0,     0},
            '{ROW_ITEM, FUNC_WRITE,   41,    0,    12, 1'b0,     0},
            '{ROW_ITEM, FUNC_QUERY,   41,    0,     0, 1'b1,    12},
            '{ROW_ITEM, FUNC_QUERY,   40,    0,     0, 1'b0,     0},
            '{ROW_ITEM, FUNC_ADD,      9,    8,     5, 1'b0,     0},
            '{ROW_ITEM, FUNC_MUL,      5,    5,     0, 1'b0,     0},
            '{ROW_ITEM, FUNC_QUERY,    5,    0,     0, 1'b1,     0},
            '{ROW_CFG,  FUNC_WRITE,   10,    0,     0, 1'b0,     0},
            '{ROW_ITEM, FUNC_WRITE,   10,    0,    99, 1'b0,     0},
            '{ROW_ITEM, FUNC_ADD,      0,   10,     1, 1'b0,     0},
            '{ROW_ITEM, FUNC_QUERY,   10,    0,     0, 1'b1,     0},
            '{ROW_CFG,  FUNC_WRITE,    0,    0,     0, 1'b0,     0},
            '{ROW_ITEM, FUNC_QUERY,    0,    0,     0, 1'b1,     0},
            '{ROW_CFG,  FUNC_WRITE, 1024,    0,     0, 1'b0,     0}
        };

        // hold everything quiet through reset
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        start       = 1'b0;
        func        = FUNC_WRITE;
        lo_index    = '0;
        hi_index    = '0;
        operand     = '0;
        fail_count  = 0;
        cycle_count = 0;
        quiet       = 1'b0;
        live_count  = MAX_ELEMENTS;
        for (int i = 0; i < MAX_ELEMENTS; i++)
        begin
            mirror_elem[i]  = 0;
            ever_written[i] = 1'b0;
        end
        for (int b = 0; b < NUM_BLOCKS; b++)
        begin
            mirror_mul[b] = 1;
            mirror_add[b] = 0;
        end
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table: extremes, every operation, ignored and empty ranges
        foreach (seq_rows[i])
        begin
            if (seq_rows[i].kind == ROW_CFG)
                write_count(seq_rows[i].lo);
            else
                send_item(seq_rows[i].f, seq_rows[i].lo, seq_rows[i].hi,
                          seq_rows[i].op, seq_rows[i].typed, seq_rows[i].val);
        end

        // random phases; the last uses a random count and no idling
        counts[6] = $urandom_range(2, 1024);
        for (int p = 0; p < 7; p++)
        begin
            write_count(counts[p]);
            quiet = (p == 6);
            repeat (items[p]) random_item();
        end

        wait_idle();
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### range_affine_mod_point_query.f
design/ramq_pkg.sv
design/ramq_ram.sv
design/ramq_modmul.sv
design/ramq_front.sv
design/ramq_back.sv
design/range_affine_mod_point_query.sv
tb/sv/range_affine_mod_point_query_tb.sv
